>>> hdl/checked_signed_alu_core_assert.svh
// Assertion macros for the checked signed ALU.
// Needs clk and rst_n in the scope of each use.
`ifndef CHECKED_SIGNED_ALU_CORE_ASSERT_SVH
`define CHECKED_SIGNED_ALU_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CSA_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("checked_signed_alu_core: assertion failed");
`define CSA_ASSERT_NEVER(name, cond) `CSA_ASSERT(name, !(cond))
`else
`define CSA_ASSERT(name, prop)
`define CSA_ASSERT_NEVER(name, cond)
`endif
`endif

>>> hdl/csa_pkg.sv
// Shared types and constants for the checked signed ALU.
// No dependencies.
`timescale 1ns / 1ps
package csa_pkg;

    localparam int DATA_W     = 64;
    localparam int DIV_STAGES = 64;
    localparam int MUL_STAGES = 4;
    localparam int MUL_DELAY  = DIV_STAGES - MUL_STAGES;

    localparam logic [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_MUL   = 4'd2,
        CMD_DIV   = 4'd3,
        CMD_MOD   = 4'd4,
        CMD_OR    = 4'd5,
        CMD_AND   = 4'd6,
        CMD_XOR   = 4'd7,
        CMD_INC   = 4'd8,
        CMD_DEC   = 4'd9,
        CMD_NEG   = 4'd10,
        CMD_LESS  = 4'd11,
        CMD_EQUAL = 4'd12
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              sign_a;
        logic              sign_b;
        logic              b_zero;
        logic              div_ovf;
        logic [DATA_W-1:0] simple_res;
        status_t           simple_st;
    } meta_t;

endpackage

>>> hdl/csa_multiplier.sv
// Four-stage 64x64 magnitude multiplier with signed overflow check.
// Depends on csa_pkg.
`timescale 1ns / 1ps
module csa_multiplier
    import csa_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DATA_W-1:0] mag_a,
    input  logic [DATA_W-1:0] mag_b,
    input  logic              neg,
    output logic              ovf,
    output logic [DATA_W-1:0] res
);

    localparam int HW = DATA_W / 2;

    logic [DATA_W-1:0]   p0_reg, p1_reg, p2_reg, p3_reg;
    logic                neg1_reg, neg2_reg, neg3_reg;
    logic [DATA_W-1:0]   lo_reg, hi_reg;
    logic [DATA_W:0]     mid_reg;
    logic [2*DATA_W-1:0] prod_reg;
    logic [2*DATA_W-1:0] prod_next;
    logic                ovf_reg, ovf_next;
    logic [DATA_W-1:0]   res_reg, res_next;

    always_comb
    begin
        prod_next = {hi_reg, lo_reg} + ({{(DATA_W-1){1'b0}}, mid_reg} << HW);
        ovf_next  = (prod_reg[2*DATA_W-1:DATA_W] != '0) ||
                    (prod_reg[DATA_W-1] && (!neg3_reg || prod_reg[DATA_W-2:0] != '0));
        res_next  = neg3_reg ? (~prod_reg[DATA_W-1:0] + 1'b1) : prod_reg[DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg   <= mag_a[HW-1:0] * mag_b[HW-1:0];
            p1_reg   <= mag_a[HW-1:0] * mag_b[DATA_W-1:HW];
            p2_reg   <= mag_a[DATA_W-1:HW] * mag_b[HW-1:0];
            p3_reg   <= mag_a[DATA_W-1:HW] * mag_b[DATA_W-1:HW];
            neg1_reg <= neg;
            lo_reg   <= p0_reg;
            hi_reg   <= p3_reg;
            mid_reg  <= {1'b0, p1_reg} + {1'b0, p2_reg};
            neg2_reg <= neg1_reg;
            prod_reg <= prod_next;
            neg3_reg <= neg2_reg;
            ovf_reg  <= ovf_next;
            res_reg  <= res_next;
        end
    end

    assign ovf = ovf_reg;
    assign res = res_reg;

endmodule

>>> hdl/csa_divider.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Depends on csa_pkg.
`timescale 1ns / 1ps
module csa_divider
    import csa_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic [DATA_W-1:0] quotient,
    output logic [DATA_W-1:0] remainder
);

    logic [DATA_W-1:0] rem_reg [DIV_STAGES];
    logic [DATA_W-1:0] num_reg [DIV_STAGES];
    logic [DATA_W-1:0] den_reg [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        logic [DATA_W-1:0] rem_in, num_in, den_in;
        logic [DATA_W:0]   trial, diff;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = dividend;
            assign den_in = divisor;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign num_in = num_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        assign trial = {rem_in, num_in[DATA_W-1]};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
                num_reg[i] <= {num_in[DATA_W-2:0], ~diff[DATA_W]};
                den_reg[i] <= den_in;
            end
        end
    end

    assign quotient  = num_reg[DIV_STAGES-1];
    assign remainder = rem_reg[DIV_STAGES-1];

endmodule

>>> hdl/checked_signed_alu_core.sv
// Path: front register, divider-depth pipe, output register. Throughput:
// one transfer per cycle unless stalled; the 64-stage divider sets the depth.
// A stall on the output freezes every stage; nothing is lost or repeated.
// rst_n (async, active low) clears all valid bits; the pipe is empty after reset.
// Top level of the checked signed ALU; depends on csa_pkg, csa_multiplier,
// csa_divider and checked_signed_alu_core_assert.svh.
`timescale 1ns / 1ps
`include "checked_signed_alu_core_assert.svh"
module checked_signed_alu_core
    import csa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // operand_a [63:0], operand_b [127:64]
    input  logic [3:0]   s_axis_tuser,   // command [3:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // result_value [63:0]
    output logic [1:0]   m_axis_tuser    // status [1:0]
);

    logic adv;

    logic              s0_valid_reg;
    cmd_t              s0_cmd_reg;
    logic [DATA_W-1:0] s0_a_reg, s0_b_reg, s0_mag_a_reg, s0_mag_b_reg;
    logic [DATA_W-1:0] in_a, in_b;

    meta_t             meta_next;
    meta_t             meta_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] valid_reg;

    logic              mul_ovf;
    logic [DATA_W-1:0] mul_res;
    logic              mul_ovf_reg [MUL_DELAY];
    logic [DATA_W-1:0] mul_res_reg [MUL_DELAY];

    logic [DATA_W-1:0] quo, rem;

    logic [DATA_W-1:0] sum, diff, inc_v, dec_v, neg_v;
    logic              ovf_add, ovf_sub, a_max, a_min;

    meta_t             fin;
    logic              fin_valid;
    logic              fin_is_div;
    logic [DATA_W-1:0] fin_res, mod_res;
    status_t           fin_st;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_res_reg;
    status_t           out_st_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_a          = s_axis_tdata[63:0];
    assign in_b          = s_axis_tdata[127:64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_cmd_reg   <= cmd_t'(s_axis_tuser);
            s0_a_reg     <= in_a;
            s0_b_reg     <= in_b;
            s0_mag_a_reg <= in_a[DATA_W-1] ? (~in_a + 1'b1) : in_a;
            s0_mag_b_reg <= in_b[DATA_W-1] ? (~in_b + 1'b1) : in_b;
        end
    end

    // simple ops resolved right after the front register
    always_comb
    begin
        sum     = s0_a_reg + s0_b_reg;
        diff    = s0_a_reg - s0_b_reg;
        inc_v   = s0_a_reg + 1'b1;
        dec_v   = s0_a_reg - 1'b1;
        neg_v   = ~s0_a_reg + 1'b1;
        ovf_add = (s0_a_reg[DATA_W-1] == s0_b_reg[DATA_W-1]) &&
                  (sum[DATA_W-1] != s0_a_reg[DATA_W-1]);
        ovf_sub = (s0_a_reg[DATA_W-1] != s0_b_reg[DATA_W-1]) &&
                  (diff[DATA_W-1] != s0_a_reg[DATA_W-1]);
        a_max   = s0_a_reg == INT_MAX;
        a_min   = s0_a_reg == INT_MIN;

        meta_next.cmd        = s0_cmd_reg;
        meta_next.a          = s0_a_reg;
        meta_next.b          = s0_b_reg;
        meta_next.sign_a     = s0_a_reg[DATA_W-1];
        meta_next.sign_b     = s0_b_reg[DATA_W-1];
        meta_next.b_zero     = s0_b_reg == '0;
        meta_next.div_ovf    = a_min && (s0_b_reg == '1);
        meta_next.simple_res = s0_a_reg;
        meta_next.simple_st  = ST_OK;

        case (s0_cmd_reg)
            CMD_ADD:
            begin
                if (ovf_add) meta_next.simple_st = ST_OVF;
                else         meta_next.simple_res = sum;
            end
            CMD_SUB:
            begin
                if (ovf_sub) meta_next.simple_st = ST_OVF;
                else         meta_next.simple_res = diff;
            end
            CMD_OR:  meta_next.simple_res = s0_a_reg | s0_b_reg;
            CMD_AND: meta_next.simple_res = s0_a_reg & s0_b_reg;
            CMD_XOR: meta_next.simple_res = s0_a_reg ^ s0_b_reg;
            CMD_INC:
            begin
                if (a_max) meta_next.simple_st = ST_OVF;
                else       meta_next.simple_res = inc_v;
            end
            CMD_DEC:
            begin
                if (a_min) meta_next.simple_st = ST_OVF;
                else       meta_next.simple_res = dec_v;
            end
            CMD_NEG:
            begin
                if (a_min) meta_next.simple_st = ST_OVF;
                else       meta_next.simple_res = neg_v;
            end
            CMD_LESS:
                meta_next.simple_res = {{(DATA_W-1){1'b0}},
                                        $signed(s0_a_reg) < $signed(s0_b_reg)};
            CMD_EQUAL:
                meta_next.simple_res = {{(DATA_W-1){1'b0}}, s0_a_reg == s0_b_reg};
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], s0_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0] <= meta_next;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
            mul_ovf_reg[0] <= mul_ovf;
            mul_res_reg[0] <= mul_res;
            for (int i = 1; i < MUL_DELAY; i++)
            begin
                mul_ovf_reg[i] <= mul_ovf_reg[i-1];
                mul_res_reg[i] <= mul_res_reg[i-1];
            end
        end
    end

    csa_multiplier u_mul (
        .clk   (clk),
        .en    (adv),
        .mag_a (s0_mag_a_reg),
        .mag_b (s0_mag_b_reg),
        .neg   (s0_a_reg[DATA_W-1] ^ s0_b_reg[DATA_W-1]),
        .ovf   (mul_ovf),
        .res   (mul_res)
    );

    csa_divider u_div (
        .clk       (clk),
        .en        (adv),
        .dividend  (s0_mag_a_reg),
        .divisor   (s0_mag_b_reg),
        .quotient  (quo),
        .remainder (rem)
    );

    assign fin        = meta_reg[DIV_STAGES-1];
    assign fin_valid  = valid_reg[DIV_STAGES-1];
    assign fin_is_div = (fin.cmd == CMD_DIV) || (fin.cmd == CMD_MOD);

    // floored modulo from the truncated remainder magnitude
    always_comb
    begin
        if (rem == '0)
            mod_res = '0;
        else if (fin.sign_a == fin.sign_b)
            mod_res = fin.sign_a ? (~rem + 1'b1) : rem;
        else if (fin.sign_a)
            mod_res = fin.b - rem;
        else
            mod_res = fin.b + rem;
    end

    always_comb
    begin
        fin_res = fin.simple_res;
        fin_st  = fin.simple_st;
        case (fin.cmd)
            CMD_MUL:
            begin
                fin_st  = mul_ovf_reg[MUL_DELAY-1] ? ST_OVF : ST_OK;
                fin_res = mul_res_reg[MUL_DELAY-1];
            end
            CMD_DIV:
            begin
                if (fin.b_zero)       fin_st = ST_DIV0;
                else if (fin.div_ovf) fin_st = ST_OVF;
                else                  fin_st = ST_OK;
                fin_res = (fin.sign_a ^ fin.sign_b) ? (~quo + 1'b1) : quo;
            end
            CMD_MOD:
            begin
                fin_st  = fin.b_zero ? ST_DIV0 : ST_OK;
                fin_res = mod_res;
            end
            default: ;
        endcase
        if (fin_st != ST_OK)
            fin_res = fin.a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_res_reg <= fin_res;
            out_st_reg  <= fin_st;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg;
    assign m_axis_tuser  = out_st_reg;

    `CSA_ASSERT(a_ready_tracks_output, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    `CSA_ASSERT(a_last_stage_reaches_out, (fin_valid && adv) |=> m_axis_tvalid)
    `CSA_ASSERT_NEVER(a_div0_only_divide, fin_valid && fin_st == ST_DIV0 && !fin_is_div)

endmodule

>>> sim/tb_top.sv
// Self-checking bench for checked_signed_alu_core: random and directed ALU transfers,
// predicted results checked in order. Depends on csa_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;
    import csa_pkg::*;

    localparam int LATENCY   = 66;
    localparam int N_RANDOM  = 1830;
    localparam longint LIMIT = 400000;

    typedef struct {
        logic [3:0]  cmd;
        logic [63:0] a;
        logic [63:0] b;
    } alu_op_t;

    typedef struct {
        logic [63:0] value;
        logic [1:0]  st;
    } alu_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // operand_a [63:0], operand_b [127:64]
    logic [3:0]   s_axis_tuser;   // command [3:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;   // result_value [63:0]
    logic [1:0]   m_axis_tuser;   // status [1:0]

    alu_op_t  pending_ops[$];
    alu_res_t expected_results[$];
    int       errors;
    bit       stim_done;
    int       hold_cycles;
    longint   cycle_count;

    checked_signed_alu_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic alu_res_t compute_alu(alu_op_t op);
        alu_res_t r;
        logic signed [63:0]  sa;
        logic signed [63:0]  sb;
        logic signed [127:0] prod;
        logic signed [63:0]  rem;
        logic [63:0]         s;
        sa = op.a;
        sb = op.b;
        r.value = op.a;
        r.st = ST_OK;
        case (op.cmd)
            CMD_ADD: begin
                s = op.a + op.b;
                if (op.a[63] == op.b[63] && s[63] != op.a[63]) r.st = ST_OVF;
                else r.value = s;
            end
            CMD_SUB: begin
                s = op.a - op.b;
                if (op.a[63] != op.b[63] && s[63] != op.a[63]) r.st = ST_OVF;
                else r.value = s;
            end
            CMD_MUL: begin
                prod = 128'(sa) * 128'(sb);
                if (prod != 128'(signed'(prod[63:0]))) r.st = ST_OVF;
                else r.value = prod[63:0];
            end
            CMD_DIV: begin
                if (op.b == 0) r.st = ST_DIV0;
                else if (op.b == '1 && op.a == INT_MIN) r.st = ST_OVF;
                else r.value = sa / sb;
            end
            CMD_MOD: begin
                if (op.b == 0) r.st = ST_DIV0;
                else if (op.b == '1) r.value = '0;
                else begin
                    rem = sa % sb;
                    if (rem != 0 && (rem[63] != sb[63])) rem = rem + sb;
                    r.value = rem;
                end
            end
            CMD_OR:  r.value = op.a | op.b;
            CMD_AND: r.value = op.a & op.b;
            CMD_XOR: r.value = op.a ^ op.b;
            CMD_INC: begin
                if (op.a == INT_MAX) r.st = ST_OVF;
                else r.value = op.a + 64'd1;
            end
            CMD_DEC: begin
                if (op.a == INT_MIN) r.st = ST_OVF;
                else r.value = op.a - 64'd1;
            end
            CMD_NEG: begin
                if (op.a == INT_MIN) r.st = ST_OVF;
                else r.value = 64'd0 - op.a;
            end
            CMD_LESS:  r.value = (sa < sb) ? 64'd1 : 64'd0;
            CMD_EQUAL: r.value = (op.a == op.b) ? 64'd1 : 64'd0;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = INT_MIN;
            1: v = INT_MAX;
            2: v = 64'($urandom_range(0, 4)) - 64'd2;
            3: v = 64'(signed'(32'($urandom)));
            4: v = 64'(signed'(16'($urandom)));
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_op(logic [3:0] cmd, logic [63:0] a, logic [63:0] b);
        alu_op_t op;
        op.cmd = cmd;
        op.a = a;
        op.b = b;
        pending_ops.push_back(op);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        int k;
        stim_done = 1'b0;
        add_op(CMD_ADD, INT_MAX, 64'd1);
        add_op(CMD_ADD, INT_MIN, '1);
        add_op(CMD_SUB, INT_MIN, 64'd1);
        add_op(CMD_SUB, INT_MAX, '1);
        add_op(CMD_MUL, INT_MIN, '1);
        add_op(CMD_MUL, INT_MAX, 64'd2);
        add_op(CMD_MUL, 64'h0000_0001_0000_0000, 64'hFFFF_FFFF_8000_0000);
        add_op(CMD_DIV, INT_MIN, '1);
        add_op(CMD_DIV, 64'd7, 64'd0);
        add_op(CMD_DIV, -64'sd7, 64'd2);
        add_op(CMD_MOD, INT_MIN, '1);
        add_op(CMD_MOD, 64'd5, 64'd0);
        add_op(CMD_MOD, -64'sd7, 64'd3);
        add_op(CMD_MOD, 64'd7, -64'sd3);
        add_op(CMD_OR, INT_MIN, 64'h5555_5555_5555_5555);
        add_op(CMD_AND, '1, 64'hAAAA_AAAA_AAAA_AAAA);
        add_op(CMD_XOR, '1, INT_MAX);
        add_op(CMD_INC, INT_MAX, '1);
        add_op(CMD_DEC, INT_MIN, '0);
        add_op(CMD_NEG, INT_MIN, '1);
        add_op(CMD_NEG, INT_MAX, '0);
        add_op(CMD_LESS, INT_MIN, INT_MAX);
        add_op(CMD_EQUAL, '1, '1);
        add_op(4'd13, '1, '1);
        add_op(4'd15, INT_MIN, '0);
        for (k = 0; k < N_RANDOM; k++)
            add_op(4'($urandom_range(0, 15)), rand_operand(), rand_operand());
        stim_done = 1'b1;
    end

    // driver
    int send_gap;
    initial send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            send_gap      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                expected_results.push_back(compute_alu(alu_op_t'{s_axis_tuser,
                    s_axis_tdata[63:0], s_axis_tdata[127:64]}));
            if (send_gap > 0 || pending_ops.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end
            else
            begin
                alu_op_t op;
                op = pending_ops.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {op.b, op.a};
                s_axis_tuser  <= op.cmd;
                send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            end
        end
    end

    // receiver stall: random gaps, with one long hold-off early in the run
    int  recv_gap;
    bit  long_hold_done;
    initial
    begin
        recv_gap = 0;
        long_hold_done = 1'b0;
        hold_cycles = 0;
    end
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (!long_hold_done && cycle_count > 200)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 300) long_hold_done <= 1'b1;
        end
        else if (recv_gap > 0)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end
        else if (!m_axis_tready || m_axis_tvalid)
        begin
            if ($urandom_range(0, 3) == 0 && m_axis_tready)
            begin
                m_axis_tready <= 1'b0;
                recv_gap <= $urandom_range(0, 18);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result value=%h status=%0d", $realtime,
                    m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                alu_res_t exp_r;
                exp_r = expected_results.pop_front();
                if (m_axis_tdata !== exp_r.value)
                begin
                    $display("%0t: value expected %h actual %h", $realtime,
                        exp_r.value, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== exp_r.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                        exp_r.st, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        cycle_count = 0;
    end
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("FAIL checked_signed_alu_core");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        wait (stim_done && pending_ops.size() == 0);
        @(posedge clk);
        while (s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("PASS checked_signed_alu_core");
        else
            $display("FAIL checked_signed_alu_core");
        $finish;
    end

endmodule

>>> checked_signed_alu_core.f
+incdir+hdl
hdl/csa_pkg.sv
hdl/csa_multiplier.sv
hdl/csa_divider.sv
hdl/checked_signed_alu_core.sv
sim/tb_top.sv
